[hw/rtl/rgb_pixel_point_operations_unit_macros.svh]
// Assertion helpers for the RTL top level; clk and rst_n come from the using module.
`ifndef RGB_PIXEL_POINT_OPERATIONS_UNIT_MACROS_SVH
`define RGB_PIXEL_POINT_OPERATIONS_UNIT_MACROS_SVH

// same-cycle implication
`define RPPO_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RPPO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/rppo_pkg.sv]
package rppo_pkg;

  localparam int GAIN_FRAC_BITS = 8;
  localparam int GAIN_W         = 12;
  localparam int THR_W          = 9;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 12;

  // product widths
  localparam int PROD_W  = 8 + GAIN_W;                       // ch * gain
  localparam int DG_W    = 9 + GAIN_W + 1;                   // (ch-128) * gain, signed
  localparam int NUM_W   = ((DG_W > 9 + GAIN_FRAC_BITS) ? DG_W : 9 + GAIN_FRAC_BITS) + 1;
  localparam int MPROD_W = 8 + 16;
  localparam int SUM_W   = 10;

  // gray = floor(sum / 3) = (sum * 683) >> 11, exact for sum <= 765
  localparam logic [SUM_W-1:0] GRAY_MUL   = SUM_W'(683);
  localparam int               GRAY_SHIFT = 11;

  // colour mix weights in 1/65536
  localparam logic [15:0] W_DEU_R = 16'd37159;
  localparam logic [15:0] W_DEU_B = 16'd28377;
  localparam logic [15:0] W_PRO_G = 16'd40698;
  localparam logic [15:0] W_PRO_B = 16'd24838;
  localparam logic [15:0] W_TRI_R = 16'd62259;
  localparam logic [15:0] W_TRI_G = 16'd3277;

  localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(128);
  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(256);

  typedef enum logic [3:0] {
    OP_RED      = 4'd0,
    OP_GRAY     = 4'd1,
    OP_BW       = 4'd2,
    OP_BRT_UP   = 4'd3,
    OP_BRT_DN   = 4'd4,
    OP_CON_UP   = 4'd5,
    OP_CON_DN   = 4'd6,
    OP_DEUTER   = 4'd7,
    OP_PROTAN   = 4'd8,
    OP_TRITAN   = 4'd9
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OPERATION = 2'd0,
    CFG_THRESHOLD = 2'd1,
    CFG_GAIN      = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
  } pix_out_t;

  // stage 1: products
  typedef struct packed {
    logic [2:0][7:0]         ch;
    logic [SUM_W-1:0]        sum;
    logic [2:0][PROD_W-1:0]  bprod;
    logic [2:0][DG_W-1:0]    dg;
    logic [5:0][MPROD_W-1:0] mprod;
  } s1_t;

  // stage 2: every candidate result, already clamped
  typedef struct packed {
    logic [2:0][7:0] ch;
    logic [7:0]      gray;
    logic [2:0][7:0] bright;
    logic [2:0][7:0] con_up;
    logic [2:0][7:0] con_dn;
    logic [7:0]      mix_r;
    logic [7:0]      mix_g;
    logic [7:0]      mix_b;
  } s2_t;

  // numerator in units of 2^-F; negative gives 0, large gives 255
  function automatic logic [7:0] scale_clamp(input logic signed [NUM_W-1:0] num);
    logic signed [NUM_W-1:0] sh;
    sh = num >>> GAIN_FRAC_BITS;
    if (num < 0)
      return 8'd0;
    else if (sh > NUM_W'(255))
      return 8'd255;
    else
      return sh[7:0];
  endfunction

endpackage

[hw/rtl/rppo_mult.sv]
module rppo_mult (
  input  logic                          clk,
  input  logic                          en,
  input  rppo_pkg::pix_in_t             pix,
  input  logic [rppo_pkg::GAIN_W-1:0]   gain,
  output rppo_pkg::s1_t                 s1_r
);

  rppo_pkg::s1_t s1_nxt;
  logic [2:0][7:0] ch;
  logic signed [rppo_pkg::GAIN_W:0] gain_s;

  assign ch     = {pix.blue_in, pix.green_in, pix.red_in};
  assign gain_s = $signed({1'b0, gain});

  always_comb begin
    s1_nxt     = '0;
    s1_nxt.ch  = ch;
    s1_nxt.sum = rppo_pkg::SUM_W'(ch[0]) + rppo_pkg::SUM_W'(ch[1])
               + rppo_pkg::SUM_W'(ch[2]);
    for (int i = 0; i < 3; i++) begin
      s1_nxt.bprod[i] = rppo_pkg::PROD_W'(ch[i]) * rppo_pkg::PROD_W'(gain);
      s1_nxt.dg[i]    = rppo_pkg::DG_W'($signed({1'b0, ch[i]} - 9'd128) * gain_s);
    end
    s1_nxt.mprod[0] = rppo_pkg::MPROD_W'(ch[0]) * rppo_pkg::MPROD_W'(rppo_pkg::W_DEU_R);
    s1_nxt.mprod[1] = rppo_pkg::MPROD_W'(ch[2]) * rppo_pkg::MPROD_W'(rppo_pkg::W_DEU_B);
    s1_nxt.mprod[2] = rppo_pkg::MPROD_W'(ch[1]) * rppo_pkg::MPROD_W'(rppo_pkg::W_PRO_G);
    s1_nxt.mprod[3] = rppo_pkg::MPROD_W'(ch[2]) * rppo_pkg::MPROD_W'(rppo_pkg::W_PRO_B);
    s1_nxt.mprod[4] = rppo_pkg::MPROD_W'(ch[0]) * rppo_pkg::MPROD_W'(rppo_pkg::W_TRI_R);
    s1_nxt.mprod[5] = rppo_pkg::MPROD_W'(ch[1]) * rppo_pkg::MPROD_W'(rppo_pkg::W_TRI_G);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= s1_nxt;
    end
  end

endmodule

[hw/rtl/rppo_scale.sv]
module rppo_scale (
  input  logic          clk,
  input  logic          en,
  input  rppo_pkg::s1_t s1,
  output rppo_pkg::s2_t s2_r
);

  localparam int F = rppo_pkg::GAIN_FRAC_BITS;
  localparam int NW = rppo_pkg::NUM_W;
  localparam int GW = rppo_pkg::SUM_W * 2;
  localparam logic signed [NW-1:0] MID_NUM = NW'(128) <<< F;

  rppo_pkg::s2_t s2_nxt;

  function automatic logic [7:0] mix_sum(input logic [rppo_pkg::MPROD_W-1:0] a,
                                         input logic [rppo_pkg::MPROD_W-1:0] b);
    logic [rppo_pkg::MPROD_W:0] s;
    logic [rppo_pkg::MPROD_W:0] sh;
    s  = {1'b0, a} + {1'b0, b};
    sh = s >> 16;
    return (sh > (rppo_pkg::MPROD_W + 1)'(255)) ? 8'd255 : sh[7:0];
  endfunction

  always_comb begin
    logic [GW-1:0]                  gprod;
    logic [rppo_pkg::PROD_W-1:0]    bsh;
    logic signed [NW-1:0]           dg_x;
    logic signed [NW-1:0]           ch_x;
    s2_nxt    = '0;
    s2_nxt.ch = s1.ch;
    gprod       = GW'(s1.sum) * GW'(rppo_pkg::GRAY_MUL);
    s2_nxt.gray = 8'(gprod >> rppo_pkg::GRAY_SHIFT);
    for (int i = 0; i < 3; i++) begin
      bsh = s1.bprod[i] >> F;
      s2_nxt.bright[i] = (bsh > rppo_pkg::PROD_W'(255)) ? 8'd255 : bsh[7:0];
      dg_x = $signed({{(NW - rppo_pkg::DG_W){s1.dg[i][rppo_pkg::DG_W-1]}}, s1.dg[i]});
      ch_x = $signed({{(NW - 8){1'b0}}, s1.ch[i]} << F);
      s2_nxt.con_up[i] = rppo_pkg::scale_clamp(dg_x + ch_x);
      s2_nxt.con_dn[i] = rppo_pkg::scale_clamp(dg_x + MID_NUM);
    end
    s2_nxt.mix_g = mix_sum(s1.mprod[0], s1.mprod[1]);
    s2_nxt.mix_r = mix_sum(s1.mprod[2], s1.mprod[3]);
    s2_nxt.mix_b = mix_sum(s1.mprod[4], s1.mprod[5]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_r <= s2_nxt;
    end
  end

endmodule

[hw/rtl/rppo_select.sv]
module rppo_select (
  input  logic                         clk,
  input  logic                         en,
  input  rppo_pkg::op_t                op,
  input  logic [rppo_pkg::THR_W-1:0]   threshold,
  input  rppo_pkg::s2_t                s2,
  output rppo_pkg::pix_out_t           pix_r
);

  rppo_pkg::pix_out_t pix_nxt;
  logic [7:0] bw;

  assign bw = (threshold > {1'b0, s2.gray}) ? 8'd0 : 8'd255;

  always_comb begin
    pix_nxt = {s2.ch[0], s2.ch[1], s2.ch[2]};
    case (op)
      rppo_pkg::OP_RED:    pix_nxt = {s2.ch[0], 8'd0, 8'd0};
      rppo_pkg::OP_GRAY:   pix_nxt = {s2.gray, s2.gray, s2.gray};
      rppo_pkg::OP_BW:     pix_nxt = {bw, bw, bw};
      rppo_pkg::OP_BRT_UP,
      rppo_pkg::OP_BRT_DN: pix_nxt = {s2.bright[0], s2.bright[1], s2.bright[2]};
      rppo_pkg::OP_CON_UP: pix_nxt = {s2.con_up[0], s2.con_up[1], s2.con_up[2]};
      rppo_pkg::OP_CON_DN: pix_nxt = {s2.con_dn[0], s2.con_dn[1], s2.con_dn[2]};
      rppo_pkg::OP_DEUTER: pix_nxt = {s2.ch[0], s2.mix_g, s2.ch[2]};
      rppo_pkg::OP_PROTAN: pix_nxt = {s2.mix_r, s2.ch[1], s2.ch[2]};
      rppo_pkg::OP_TRITAN: pix_nxt = {s2.ch[0], s2.ch[1], s2.mix_b};
      default:             pix_nxt = {s2.ch[0], s2.ch[1], s2.ch[2]}; // unused codes pass
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pix_r <= pix_nxt;
    end
  end

endmodule

[hw/rtl/rgb_pixel_point_operations_unit.sv]
// Channel   Dir  Handshake           Payload
// in_       in   in_valid/in_stall   pix_in_t  (red_in, green_in, blue_in)
// out_      out  out_valid/out_stall pix_out_t (red_out, green_out, blue_out)
// cfg_      in   cfg_valid/cfg_ready cfg_index (2b), cfg_data (12b)
//
// Three register stages: products, scale/clamp, mode select into the output register.
// One pixel per clock sustained while out_stall is low; out_valid rises when a pixel reaches the output register.
// Each stage holds when the stage after it is full and blocked, so bubbles collapse;
// in_stall is raised only with all three stages full and out_stall high.
// Synchronous active-low reset clears the stage valids and loads the register defaults.
// cfg_ready is always high; writes take effect on the next cycle.
`include "rgb_pixel_point_operations_unit_macros.svh"

module rgb_pixel_point_operations_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  rppo_pkg::pix_in_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output rppo_pkg::pix_out_t                out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rppo_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rppo_pkg::CFG_DATA_W-1:0]   cfg_data
);

  rppo_pkg::op_t                 op_r;
  logic [rppo_pkg::THR_W-1:0]    thr_r;
  logic [rppo_pkg::GAIN_W-1:0]   gain_r;

  logic s1_v_r, s2_v_r, out_v_r;
  logic adv1, adv2, adv3;
  logic pipe_full, cfg_op_wr;

  rppo_pkg::s1_t s1;
  rppo_pkg::s2_t s2;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r   <= rppo_pkg::OP_GRAY;
      thr_r  <= rppo_pkg::THR_RESET;
      gain_r <= rppo_pkg::GAIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rppo_pkg::CFG_OPERATION: op_r   <= rppo_pkg::op_t'(cfg_data[3:0]);
        rppo_pkg::CFG_THRESHOLD: thr_r  <= cfg_data[rppo_pkg::THR_W-1:0];
        rppo_pkg::CFG_GAIN:      gain_r <= cfg_data[rppo_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // a stage may load when it is empty or its contents move on this cycle
  assign adv3 = !out_v_r || !out_stall;
  assign adv2 = !s2_v_r || adv3;
  assign adv1 = !s1_v_r || adv2;
  assign in_stall  = !adv1;
  assign out_valid = out_v_r;

  assign pipe_full = s1_v_r && s2_v_r && out_v_r;
  assign cfg_op_wr = cfg_valid && cfg_ready && cfg_index == rppo_pkg::CFG_OPERATION;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (adv1) begin
        s1_v_r <= in_valid;
      end
      if (adv2) begin
        s2_v_r <= s1_v_r;
      end
      if (adv3) begin
        out_v_r <= s2_v_r;
      end
    end
  end

  rppo_mult u_mult (
    .clk  (clk),
    .en   (adv1 && in_valid),
    .pix  (in_data),
    .gain (gain_r),
    .s1_r (s1)
  );

  rppo_scale u_scale (
    .clk  (clk),
    .en   (adv2 && s1_v_r),
    .s1   (s1),
    .s2_r (s2)
  );

  rppo_select u_select (
    .clk       (clk),
    .en        (adv3 && s2_v_r),
    .op        (op_r),
    .threshold (thr_r),
    .s2        (s2),
    .pix_r     (out_data)
  );

  `RPPO_ASSERT_NOW(a_stall_full, in_stall, pipe_full && out_stall, "stall with a free stage")
  `RPPO_ASSERT_NEXT(a_s2_moves, s2_v_r && adv3, out_v_r, "stage two item lost on its way out")
  `RPPO_ASSERT_NEXT(a_op_write, cfg_op_wr, 4'(op_r) == $past(cfg_data[3:0]), "op write lost")

endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

  localparam int CLK_HALF        = 4;
  localparam int RESET_CYCLES    = 8;
  localparam int SETTLE_CYCLES   = 4;     // three pipeline stages plus margin
  localparam int QUIET_LIMIT     = 2000;
  localparam int ITEMS_PER_PHASE = 345;
  localparam int MID             = 128;

  localparam logic [rppo_pkg::CFG_IDX_W-1:0] CFG_NO_REG = 2'd3;
  localparam logic [3:0]           OP_FIRST_UNUSED = 4'd10;
  localparam logic [3:0]           OP_LAST_UNUSED  = 4'd15;

  // colour-blindness mix weights, 1/65536
  localparam int DEU_R = 37159;
  localparam int DEU_B = 28377;
  localparam int PRO_G = 40698;
  localparam int PRO_B = 24838;
  localparam int TRI_R = 62259;
  localparam int TRI_G = 3277;

  logic                            clk;
  logic                            rst_n     = 1'b0;
  logic                            in_valid  = 1'b0;
  logic                            in_stall;
  rppo_pkg::pix_in_t               in_data   = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  rppo_pkg::pix_out_t              out_data;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [rppo_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [rppo_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  // shadow copy of the block's registers, at reset values
  logic [3:0]  op_reg   = rppo_pkg::OP_GRAY;
  logic [8:0]  thr_reg  = 9'd128;
  logic [11:0] gain_reg = 12'd256;

  rppo_pkg::pix_out_t pixel_q[$];
  int       errors       = 0;
  int       n_checked    = 0;
  int       n_writes     = 0;
  int       quiet_cycles = 0;
  int       gap_pct      = 0;
  int       stall_pct    = 0;

  rgb_pixel_point_operations_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  function automatic int clamp_byte(int v);
    if (v < 0) return 0;
    return (v > 255) ? 255 : v;
  endfunction

  function automatic rppo_pkg::pix_out_t predict_pixel(rppo_pkg::pix_in_t px);
    int                 ch[3];
    int                 res[3];
    int                 gray;
    int                 g;
    int                 num;
    rppo_pkg::pix_out_t po;
    ch[0] = px.red_in;
    ch[1] = px.green_in;
    ch[2] = px.blue_in;
    res   = ch;
    g     = gain_reg;
    gray  = (ch[0] + ch[1] + ch[2]) / 3;
    case (op_reg)
      rppo_pkg::OP_RED: begin
        res[1] = 0;
        res[2] = 0;
      end
      rppo_pkg::OP_GRAY: foreach (res[i]) res[i] = gray;
      rppo_pkg::OP_BW: foreach (res[i]) res[i] = (int'(thr_reg) > gray) ? 0 : 255;
      rppo_pkg::OP_BRT_UP, rppo_pkg::OP_BRT_DN: begin
        foreach (res[i]) res[i] = clamp_byte((ch[i] * g) >>> rppo_pkg::GAIN_FRAC_BITS);
      end
      rppo_pkg::OP_CON_UP: begin
        foreach (res[i]) begin
          num    = (ch[i] - MID) * g + (ch[i] <<< rppo_pkg::GAIN_FRAC_BITS);
          res[i] = (num < 0) ? 0 : clamp_byte(num >>> rppo_pkg::GAIN_FRAC_BITS);
        end
      end
      rppo_pkg::OP_CON_DN: begin
        foreach (res[i]) begin
          num    = (ch[i] - MID) * g + (MID <<< rppo_pkg::GAIN_FRAC_BITS);
          res[i] = (num < 0) ? 0 : clamp_byte(num >>> rppo_pkg::GAIN_FRAC_BITS);
        end
      end
      rppo_pkg::OP_DEUTER: res[1] = clamp_byte((ch[0] * DEU_R + ch[2] * DEU_B) >>> 16);
      rppo_pkg::OP_PROTAN: res[0] = clamp_byte((ch[1] * PRO_G + ch[2] * PRO_B) >>> 16);
      rppo_pkg::OP_TRITAN: res[2] = clamp_byte((ch[0] * TRI_R + ch[1] * TRI_G) >>> 16);
      default: ;  // unused codes pass the pixel through
    endcase
    po.red_out   = 8'(res[0]);
    po.green_out = 8'(res[1]);
    po.blue_out  = 8'(res[2]);
    return po;
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // result check before the new pixel is queued, so a transfer out never meets this edge's input
  always @(posedge clk) begin
    rppo_pkg::pix_out_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pixel_q.size() == 0) begin
          $error("result %h with no pixel outstanding", out_data);
          errors++;
        end else begin
          want = pixel_q.pop_front();
          check_field("red_out", want.red_out, out_data.red_out);
          check_field("green_out", want.green_out, out_data.green_out);
          check_field("blue_out", want.blue_out, out_data.blue_out);
          n_checked++;
        end
      end
      if (in_valid && !in_stall) pixel_q = {pixel_q, predict_pixel(in_data)};
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("rgb_pixel_point_operations_unit test failed");
    $finish;
  end

  function automatic rppo_pkg::pix_in_t mk_pixel(int r, int g, int b);
    rppo_pkg::pix_in_t px;
    px.red_in   = 8'(r);
    px.green_in = 8'(g);
    px.blue_in  = 8'(b);
    return px;
  endfunction

  task automatic send_pixel(input rppo_pkg::pix_in_t px);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    do @(posedge clk); while (in_stall);
  endtask

  // hold off the sender until the pipeline has drained
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [rppo_pkg::CFG_IDX_W-1:0]  idx,
                           input logic [rppo_pkg::CFG_DATA_W-1:0] data);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      rppo_pkg::CFG_OPERATION: op_reg   = data[3:0];
      rppo_pkg::CFG_THRESHOLD: thr_reg  = data[8:0];
      rppo_pkg::CFG_GAIN:      gain_reg = data[11:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
    n_writes++;
  endtask

  // gray, threshold and gain all checked at their reset values
  task automatic test_reset_values();
    send_pixel(mk_pixel(0, 0, 0));
    send_pixel(mk_pixel(255, 255, 255));
    send_pixel(mk_pixel(1, 2, 4));
    write_reg(rppo_pkg::CFG_OPERATION, 12'(rppo_pkg::OP_BW));
    send_pixel(mk_pixel(127, 127, 128));
    send_pixel(mk_pixel(128, 128, 129));
    write_reg(rppo_pkg::CFG_OPERATION, 12'(rppo_pkg::OP_BRT_UP));
    send_pixel(mk_pixel(255, 128, 1));
  endtask

  task automatic test_threshold();
    write_reg(rppo_pkg::CFG_OPERATION, 12'(rppo_pkg::OP_BW));
    write_reg(rppo_pkg::CFG_THRESHOLD, 12'd0);
    send_pixel(mk_pixel(0, 0, 0));
    write_reg(rppo_pkg::CFG_THRESHOLD, 12'd256);
    send_pixel(mk_pixel(255, 255, 255));
    write_reg(rppo_pkg::CFG_THRESHOLD, 12'hFFF);
    send_pixel(mk_pixel(255, 255, 255));
  endtask

  task automatic test_brightness();
    write_reg(rppo_pkg::CFG_GAIN, 12'hFFF);
    write_reg(rppo_pkg::CFG_OPERATION, 12'(rppo_pkg::OP_BRT_UP));
    send_pixel(mk_pixel(255, 16, 1));
    write_reg(rppo_pkg::CFG_OPERATION, 12'(rppo_pkg::OP_BRT_DN));
    send_pixel(mk_pixel(255, 16, 1));
    write_reg(rppo_pkg::CFG_GAIN, 12'd0);
    send_pixel(mk_pixel(255, 255, 255));
  endtask

  // large gain drives both ends of the clamp, zero gain leaves contrast flat
  task automatic test_contrast();
    write_reg(rppo_pkg::CFG_GAIN, 12'hFFF);
    write_reg(rppo_pkg::CFG_OPERATION, 12'(rppo_pkg::OP_CON_UP));
    send_pixel(mk_pixel(0, 128, 255));
    write_reg(rppo_pkg::CFG_OPERATION, 12'(rppo_pkg::OP_CON_DN));
    send_pixel(mk_pixel(0, 128, 255));
    write_reg(rppo_pkg::CFG_GAIN, 12'd0);
    send_pixel(mk_pixel(0, 127, 255));
    write_reg(rppo_pkg::CFG_OPERATION, 12'(rppo_pkg::OP_CON_UP));
    send_pixel(mk_pixel(0, 127, 255));
  endtask

  task automatic test_colour_mixes();
    write_reg(rppo_pkg::CFG_OPERATION, 12'(rppo_pkg::OP_DEUTER));
    send_pixel(mk_pixel(255, 255, 255));
    send_pixel(mk_pixel(37, 201, 143));
    write_reg(rppo_pkg::CFG_OPERATION, 12'(rppo_pkg::OP_PROTAN));
    send_pixel(mk_pixel(255, 255, 255));
    send_pixel(mk_pixel(37, 201, 143));
    write_reg(rppo_pkg::CFG_OPERATION, 12'(rppo_pkg::OP_TRITAN));
    send_pixel(mk_pixel(255, 255, 255));
    send_pixel(mk_pixel(37, 201, 143));
  endtask

  // unused operation codes, masked upper data bits and the spare register index
  task automatic test_unused_codes();
    write_reg(rppo_pkg::CFG_OPERATION, {8'hFF, OP_LAST_UNUSED});
    send_pixel(mk_pixel(1, 2, 3));
    write_reg(rppo_pkg::CFG_OPERATION, {8'h5A, OP_FIRST_UNUSED});
    send_pixel(mk_pixel(200, 100, 50));
    write_reg(rppo_pkg::CFG_OPERATION, {8'hA5, rppo_pkg::OP_RED});
    write_reg(CFG_NO_REG, 12'(rppo_pkg::OP_GRAY));
    send_pixel(mk_pixel(90, 180, 45));
  endtask

  function automatic logic [7:0] pick_level();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'(MID);
      3: return 8'(MID - 1);
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [8:0] pick_threshold();
    case ($urandom_range(5))
      0: return 9'd0;
      1: return 9'd255;
      2: return 9'd256;
      3: return 9'd511;
      default: return 9'($urandom);
    endcase
  endfunction

  function automatic logic [11:0] pick_gain();
    case ($urandom_range(6))
      0: return 12'd0;
      1: return 12'd256;
      2: return 12'hFFF;
      3: return 12'($urandom_range(511));
      default: return 12'($urandom);
    endcase
  endfunction

  task automatic pick_random_config();
    logic [3:0] op;
    if ($urandom_range(9) == 0)
      op = 4'($urandom_range(OP_LAST_UNUSED, OP_FIRST_UNUSED));
    else
      op = 4'($urandom_range(rppo_pkg::OP_TRITAN, rppo_pkg::OP_RED));
    write_reg(rppo_pkg::CFG_OPERATION, {8'($urandom), op});
    if ($urandom_range(1)) write_reg(rppo_pkg::CFG_THRESHOLD, {3'($urandom), pick_threshold()});
    if ($urandom_range(1)) write_reg(rppo_pkg::CFG_GAIN, pick_gain());
    if ($urandom_range(7) == 0) write_reg(CFG_NO_REG, 12'($urandom));
  endtask

  task automatic test_random_traffic(input int gap, input int stall);
    int sent;
    int burst;
    gap_pct   = gap;
    stall_pct = stall;
    sent      = 0;
    while (sent < ITEMS_PER_PHASE) begin
      pick_random_config();
      burst = $urandom_range(30, 5);
      for (int j = 0; j < burst && sent < ITEMS_PER_PHASE; j++) begin
        send_pixel(mk_pixel(pick_level(), pick_level(), pick_level()));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    gap_pct   = 31;
    stall_pct = 56;
    test_reset_values();
    test_threshold();
    test_brightness();
    test_contrast();
    test_colour_mixes();
    test_unused_codes();
    test_random_traffic(31, 56);
    test_random_traffic(56, 31);
    test_random_traffic(0, 0);
    drain();
    $display("Checked %0d pixels over all ten operations, unused codes and the spare index",
             n_checked);
    $display("%0d register writes with threshold and gain at both ends, %0d mismatches",
             n_writes, errors);
    if (errors == 0)
      $display("rgb_pixel_point_operations_unit test passed");
    else
      $display("rgb_pixel_point_operations_unit test failed");
    $finish;
  end

endmodule
